/* sv/int_to_text_any_radix_defines.svh */
// Assertion macros shared by the modules of the integer to text converter.
`ifndef INT_TO_TEXT_ANY_RADIX_DEFINES_SVH
`define INT_TO_TEXT_ANY_RADIX_DEFINES_SVH

// Checked on every rising edge of i_clk, and switched off while reset is low.
`define ITAR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define ITAR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* sv/itar_pkg.sv */
`default_nettype none

package itar_pkg;

    localparam int WORD_BITS  = 32;
    localparam int CHUNK_BITS = 8;
    localparam int CHUNKS     = (WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int STEP_BITS  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int IDX_BITS   = $clog2(WORD_BITS);
    localparam int CNT_BITS   = $clog2(WORD_BITS + 1);
    localparam int RADIX_BITS = 6;
    localparam int CHAR_BITS  = 8;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO      = 8'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_LETTER_A  = 8'd65;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS     = 8'd45;
    localparam logic [CHAR_BITS-1:0] DECIMAL_DIGITS = 8'd10;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_first;
        logic div_last;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic q_zero;
        logic neg;
        logic idx_zero;
        logic out_free;
    } t_sts;

    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [RADIX_BITS-1:0] d);
        logic [CHAR_BITS-1:0] dw;
        dw = CHAR_BITS'(d);
        if (dw < DECIMAL_DIGITS) begin
            return CHAR_ZERO + dw;
        end
        return CHAR_LETTER_A + (dw - DECIMAL_DIGITS);
    endfunction

endpackage

`default_nettype wire

/* sv/itar_ctrl.sv */
`default_nettype none

`include "int_to_text_any_radix_defines.svh"

module itar_ctrl
    import itar_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output t_cmd      o_cmd,
    input  t_sts      i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state               r_state, n_state;
    logic [STEP_BITS-1:0] r_step, n_step;
    logic                 step_last;

    assign step_last  = (r_step == STEP_BITS'(CHUNKS - 1));
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.div_first  = (r_state == S_DIV) && (r_step == '0);
        o_cmd.div_last   = (r_state == S_DIV) && step_last;
        o_cmd.emit_sign  = (r_state == S_SIGN) && i_sts.out_free;
        o_cmd.emit_digit = (r_state == S_EMIT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_step = r_step + 1'b1;
                if (step_last) begin
                    n_step = '0;
                    if (i_sts.q_zero) begin
                        n_state = i_sts.neg ? S_SIGN : S_EMIT;
                    end
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free && i_sts.idx_zero) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    `ITAR_ASSERT(a_accept_starts_div, (i_in_valid && o_in_ready) |=> (r_state == S_DIV), "accepted beat did not start division")
    `ITAR_ASSERT(a_emit_needs_room, (o_cmd.emit_sign || o_cmd.emit_digit) |-> i_sts.out_free, "character emitted while output register busy")
    `ITAR_ASSERT(a_final_digit_idles, (o_cmd.emit_digit && i_sts.idx_zero) |=> (r_state == S_IDLE), "no return to idle after final character")

endmodule

`default_nettype wire

/* sv/itar_dp.sv */
`default_nettype none

`include "int_to_text_any_radix_defines.svh"

module itar_dp
    import itar_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [WORD_BITS-1:0]  i_value,
    input  wire logic                  i_cfg_valid,
    input  wire logic [RADIX_BITS-1:0] i_cfg_data,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [CHAR_BITS-1:0]       o_out_char,
    output logic                       o_out_last
);

    logic [RADIX_BITS-1:0] r_radix;
    logic [RADIX_BITS-1:0] base;
    logic [WORD_BITS-1:0]  r_q, n_q;
    logic [RADIX_BITS-1:0] r_rem;
    logic                  r_neg;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [IDX_BITS-1:0]   r_idx;
    logic [RADIX_BITS-1:0] r_digits [WORD_BITS];
    logic                  r_out_valid;
    logic [CHAR_BITS-1:0]  r_out_char;
    logic                  r_out_last;

    logic [WORD_BITS-1:0]  magnitude;
    logic [CHUNK_BITS-1:0] chunk;
    logic [CHUNK_BITS-1:0] qbits;
    logic [RADIX_BITS:0]   rem;
    logic                  out_free;

    always_comb begin
        if (r_radix < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            base = RADIX_MAX;
        end else begin
            base = r_radix;
        end
    end

    assign magnitude = i_value[WORD_BITS-1] ? (WORD_BITS'(0) - i_value) : i_value;

    // Restoring long division of the top chunk of the quotient register.
    always_comb begin
        chunk = r_q[WORD_BITS-1 -: CHUNK_BITS];
        rem   = i_cmd.div_first ? '0 : {1'b0, r_rem};
        qbits = '0;
        for (int i = 0; i < CHUNK_BITS; i++) begin
            rem = {rem[RADIX_BITS-1:0], chunk[CHUNK_BITS-1-i]};
            if (rem >= {1'b0, base}) begin
                rem = rem - {1'b0, base};
                qbits[CHUNK_BITS-1-i] = 1'b1;
            end
        end
        n_q = (r_q << CHUNK_BITS) | WORD_BITS'(qbits);
    end

    assign out_free       = !r_out_valid || i_out_ready;
    assign o_sts.q_zero   = (n_q == '0);
    assign o_sts.neg      = r_neg;
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= RADIX_RESET;
            r_q         <= '0;
            r_neg       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_radix <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_q   <= magnitude;
                r_neg <= i_value[WORD_BITS-1];
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_q <= n_q;
                if (i_cmd.div_last) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.emit_sign || i_cmd.emit_digit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step) begin
            r_rem <= rem[RADIX_BITS-1:0];
        end
        if (i_cmd.div_last) begin
            r_digits[r_cnt[IDX_BITS-1:0]] <= rem[RADIX_BITS-1:0];
            if (n_q == '0) begin
                r_idx <= r_cnt[IDX_BITS-1:0];
            end
        end
        if (i_cmd.emit_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= digit_to_ascii(r_digits[r_idx]);
            r_out_last <= (r_idx == '0);
            r_idx      <= r_idx - 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

    `ITAR_ASSERT(a_count_bound, r_cnt <= CNT_BITS'(WORD_BITS), "digit count beyond word width")

endmodule

`default_nettype wire

/* sv/int_to_text_any_radix.sv */
// Converts one signed 32-bit integer per input beat into ASCII text, one character per beat.
// Each digit takes a pass over every chunk; the divider retires eight quotient bits per cycle.
// The first character is the minus sign when the value is negative.
// A new integer is taken only after the final character is registered.
// Reset is synchronous and active low; it idles the controller and sets the radix to ten.
`default_nettype none

module int_to_text_any_radix
    import itar_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [WORD_BITS-1:0]  s_axis_tdata,  // [31:0] value
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [CHAR_BITS-1:0]       m_axis_tdata,  // [7:0] character
    output logic                       m_axis_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [RADIX_BITS-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    itar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    itar_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_char  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* bench/int_to_text_checker.sv */
module int_to_text_checker
    import itar_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [WORD_BITS-1:0]  i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [CHAR_BITS-1:0]  i_out_data,
    input  logic                  i_out_last,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [RADIX_BITS-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_chars_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAR_BITS-1:0] code;
        logic                 is_final;
    } text_char_t;

    text_char_t            expected_text[$];
    logic [RADIX_BITS-1:0] radix_copy = RADIX_RESET;
    int                    mismatch_count = 0;
    int                    char_count = 0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t ns] mismatch: %s", $realtime, what);
    endtask

    // Queues the characters of one value, sign first and then the digits from the top down.
    function automatic void predict_text(input logic [WORD_BITS-1:0] value);
        logic [WORD_BITS-1:0]  magnitude;
        logic [WORD_BITS-1:0]  base;
        logic [RADIX_BITS-1:0] digits [WORD_BITS];
        int                    count;
        text_char_t            entry;
        if (radix_copy < RADIX_MIN) begin
            base = WORD_BITS'(RADIX_MIN);
        end else if (radix_copy > RADIX_MAX) begin
            base = WORD_BITS'(RADIX_MAX);
        end else begin
            base = WORD_BITS'(radix_copy);
        end
        magnitude = value[WORD_BITS-1] ? (~value + 1'b1) : value;
        count = 0;
        do begin
            digits[count] = RADIX_BITS'(magnitude % base);
            count++;
            magnitude = magnitude / base;
        end while (magnitude != 0);
        if (value[WORD_BITS-1]) begin
            entry.code     = CHAR_MINUS;
            entry.is_final = 1'b0;
            expected_text.push_back(entry);
        end
        for (int i = count - 1; i >= 0; i--) begin
            if (CHAR_BITS'(digits[i]) < DECIMAL_DIGITS) begin
                entry.code = CHAR_ZERO + CHAR_BITS'(digits[i]);
            end else begin
                entry.code = CHAR_LETTER_A + CHAR_BITS'(digits[i]) - DECIMAL_DIGITS;
            end
            entry.is_final = (i == 0);
            expected_text.push_back(entry);
        end
    endfunction

    task automatic check_char();
        text_char_t want;
        if (expected_text.size() == 0) begin
            report_mismatch($sformatf("character 0x%02h arrived with nothing expected",
                                      i_out_data));
        end else begin
            want = expected_text.pop_front();
            char_count++;
            if (i_out_data !== want.code) begin
                report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                          i_out_data, want.code));
            end
            if (i_out_last !== want.is_final) begin
                report_mismatch($sformatf("last flag %b, expected %b on character 0x%02h",
                                          i_out_last, want.is_final, want.code));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_copy = RADIX_RESET;
            expected_text.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                radix_copy = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                check_char();
            end
            if (i_in_valid && i_in_ready) begin
                predict_text(i_in_data);
            end
        end
        o_pending       <= expected_text.size();
        o_mismatches    <= mismatch_count;
        o_chars_checked <= char_count;
    end

endmodule

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import itar_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [WORD_BITS-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [CHAR_BITS-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [RADIX_BITS-1:0] i_cfg_data;

    int mismatches;
    int pending;
    int chars_checked;
    int values_sent;
    int radix_writes;
    bit steady_flow;

    int_to_text_any_radix u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    int_to_text_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .i_in_ready      (s_axis_tready),
        .i_in_data       (s_axis_tdata),
        .i_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .i_out_data      (m_axis_tdata),
        .i_out_last      (m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_chars_checked (chars_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 19);
    end

    // The valid line is only lowered when a gap is drawn, so back-to-back beats keep it high.
    task automatic send_value(input logic [WORD_BITS-1:0] value);
        while (!steady_flow && $urandom_range(0, 99) < 19) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        values_sent++;
    endtask

    task automatic drain_text();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [RADIX_BITS-1:0] radix);
        drain_text();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= radix;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        radix_writes++;
    endtask

    function automatic logic [WORD_BITS-1:0] random_value();
        logic [WORD_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6:          v = $urandom >> $urandom_range(1, 31);
            7:             v = -($urandom_range(0, 1000));
            8: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hffff_ffff;
                endcase
            end
            default:       v = -($urandom >> $urandom_range(1, 31));
        endcase
        return v;
    endfunction

    initial begin
        logic [RADIX_BITS-1:0] phase_radix [8];
        phase_radix = '{6'd10, 6'd16, 6'd2, 6'd36, 6'd7, 6'd0, 6'd63, 6'd1};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        values_sent   = 0;
        radix_writes  = 0;
        steady_flow   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The radix comes out of reset as ten.
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hffff_ffff);
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(32'd999_999_999);

        write_radix(6'd2);
        send_value(32'h8000_0000);
        send_value(32'h7fff_ffff);
        send_value(32'hffff_ffff);
        send_value(32'd0);
        send_value(32'd1);

        write_radix(6'd36);
        send_value(32'd35);
        send_value(32'd36);
        send_value(-32'sd35);
        send_value(32'h8000_0000);
        send_value(32'h7fff_ffff);
        send_value(32'd0);

        // Out-of-range radix settings saturate to two or thirty-six.
        write_radix(6'd0);
        send_value(32'd5);
        send_value(-32'sd5);
        write_radix(6'd1);
        send_value(32'd3);
        write_radix(6'd63);
        send_value(32'd12345);
        write_radix(6'd37);
        send_value(32'd36);

        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 5) begin
                write_radix(6'($urandom_range(0, 63)));
            end else begin
                write_radix(phase_radix[phase]);
            end
            steady_flow <= (phase == 3);
            for (int n = 0; n < 43; n++) begin
                send_value(random_value());
            end
        end
        write_radix(6'($urandom_range(2, 36)));
        steady_flow <= 1'b0;
        for (int n = 0; n < 12; n++) begin
            send_value(random_value());
        end

        drain_text();
        repeat (200) @(posedge i_clk);
        $display("Converted %0d values under %0d radix writes, %0d characters compared.",
                 values_sent, radix_writes, chars_checked);
        $display("Radix settings ran from below two to above thirty-six, with random stalls.");
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* int_to_text_any_radix.f */
+incdir+sv
sv/itar_pkg.sv
sv/itar_ctrl.sv
sv/itar_dp.sv
sv/int_to_text_any_radix.sv
bench/int_to_text_checker.sv
bench/testbench.sv
